>>> src/triangle_scanline_span_defines.svh
// assertion macros for the triangle scanline span block
// used by the top level only, no other dependencies
`ifndef TRIANGLE_SCANLINE_SPAN_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_DEFINES_SVH
`ifndef SYNTHESIS
`define TSS_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("span assertion failed");
`define TSS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("span assertion failed");
`else
`define TSS_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define TSS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

>>> src/tss_pkg.sv
// shared types, constants and the divider start, step and finish functions of the scanline span block
// no dependencies
package tss_pkg;

    localparam int COORD_BITS  = 16;
    localparam int MAX_DIM     = 4096;
    localparam int DIM_BITS    = 13;
    localparam int ROW_BITS    = 12;
    localparam int COLOR_BITS  = 24;
    localparam int DX_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DX_BITS;
    localparam int NUM_BITS    = PROD_BITS + 1;
    localparam int DVS_BITS    = COORD_BITS + 1;
    localparam int Q_BITS      = COORD_BITS + 2;
    localparam int X_BITS      = COORD_BITS + 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    localparam logic [DIM_BITS-1:0] MAX_DIM_VAL = DIM_BITS'(MAX_DIM);
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // one edge after classification
    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [DX_BITS-1:0]    dx;
        logic [COORD_BITS-1:0]        t;
        logic [COORD_BITS-1:0]        den;
        logic                         flat;
    } tss_edge_t;

    typedef struct packed {
        logic                  row_ok;
        tss_edge_t             edge_a;
        tss_edge_t             edge_b;
        logic [COLOR_BITS-1:0] color;
    } tss_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [PROD_BITS-1:0]  prod;
        logic [COORD_BITS-1:0]        den;
        logic                         flat;
    } tss_prod_t;

    typedef struct packed {
        logic                  row_ok;
        tss_prod_t             pa;
        tss_prod_t             pb;
        logic [COLOR_BITS-1:0] color;
    } tss_mwork_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic [NUM_BITS-1:0]          rem;
        logic [DVS_BITS-1:0]          dvs;
        logic [Q_BITS-1:0]            quo;
        logic                         neg;
        logic                         flat;
    } tss_div_t;

    typedef struct packed {
        logic                  row_ok;
        tss_div_t              da;
        tss_div_t              db;
        logic [COLOR_BITS-1:0] color;
    } tss_dwork_t;

    typedef struct packed {
        logic                  row_ok;
        logic signed [X_BITS-1:0] xa;
        logic signed [X_BITS-1:0] xb;
        logic [COLOR_BITS-1:0] color;
    } tss_fwork_t;

    typedef struct packed {
        logic                  covered;
        logic [ROW_BITS-1:0]   start;
        logic [ROW_BITS-1:0]   stop;
        logic [COLOR_BITS-1:0] color;
    } tss_span_t;

    // one restoring division step at quotient bit k
    function automatic tss_div_t div_step(tss_div_t d, int unsigned k);
        tss_div_t r;
        logic [NUM_BITS-1:0] dsh;
        r = d;
        dsh = {{(NUM_BITS-DVS_BITS){1'b0}}, d.dvs} << k;
        if (d.rem >= dsh)
        begin
            r.rem = d.rem - dsh;
            r.quo = d.quo | (Q_BITS'(1) << k);
        end
        return r;
    endfunction

    // product to rounded numerator magnitude, divisor twice the height
    function automatic tss_div_t div_start(tss_prod_t p);
        tss_div_t r;
        logic signed [NUM_BITS-1:0] num;
        num = signed'({p.prod, 1'b0}) + signed'({{(NUM_BITS-COORD_BITS){1'b0}}, p.den});
        r.sx   = p.sx;
        r.neg  = num[NUM_BITS-1];
        r.rem  = r.neg ? NUM_BITS'(-num) : NUM_BITS'(num);
        r.dvs  = {p.den, 1'b0};
        r.quo  = '0;
        r.flat = p.flat;
        return r;
    endfunction

    // floor quotient and edge x
    function automatic logic signed [X_BITS-1:0] div_finish(tss_div_t d);
        logic signed [X_BITS-1:0] qv;
        logic signed [X_BITS-1:0] sxe;
        qv  = signed'({{(X_BITS-Q_BITS){1'b0}}, d.quo});
        sxe = X_BITS'(d.sx);
        if (d.neg)
        begin
            qv = -(qv + X_BITS'(d.rem != '0));
        end
        return d.flat ? sxe : (sxe + qv);
    endfunction

endpackage

>>> src/tss_front.sv
// front part: sorts the vertices by y and classifies the row and edges
// depends on tss_pkg
module tss_front
(
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_a_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_a_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_b_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_b_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_c_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_c_y,
    input  logic [tss_pkg::ROW_BITS-1:0]          row,
    input  logic [tss_pkg::COLOR_BITS-1:0]        fill_color,
    input  logic [tss_pkg::DIM_BITS-1:0]          frame_height,
    output tss_pkg::tss_item_t                    item
);

    localparam int CB = tss_pkg::COORD_BITS;
    localparam int WB = CB + 2;

    logic signed [CB-1:0] x0, y0, x1, y1, x2, y2, tx, ty;
    logic signed [WB-1:0] rw;
    logic [tss_pkg::DIM_BITS-1:0] h;

    function automatic tss_pkg::tss_edge_t make_edge(logic signed [WB-1:0] r,
        logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
        logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
        tss_pkg::tss_edge_t e;
        logic signed [WB-1:0] t_w, den_w, dx_w;
        t_w   = r - WB'(sy);
        den_w = WB'(ey) - WB'(sy);
        dx_w  = WB'(ex) - WB'(sx);
        e.sx   = sx;
        e.dx   = dx_w[tss_pkg::DX_BITS-1:0];
        e.t    = t_w[CB-1:0];
        e.den  = den_w[CB-1:0];
        e.flat = (sy == ey);
        return e;
    endfunction

    // stable three element sort by y
    always_comb
    begin
        tx = '0;
        ty = '0;
        x0 = vertex_a_x; y0 = vertex_a_y;
        x1 = vertex_b_x; y1 = vertex_b_y;
        x2 = vertex_c_x; y2 = vertex_c_y;
        if (y0 > y1)
        begin
            tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
        end
        if (y1 > y2)
        begin
            tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
        end
        if (y0 > y1)
        begin
            tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
        end
    end

    // row test and edge selection
    always_comb
    begin
        rw = signed'({{(WB-tss_pkg::ROW_BITS){1'b0}}, row});
        h  = (frame_height > tss_pkg::MAX_DIM_VAL) ? tss_pkg::MAX_DIM_VAL : frame_height;
        item.row_ok = (rw >= WB'(y0)) && (rw <= WB'(y2))
                      && ({1'b0, row} < h);
        if (rw < WB'(y1))
        begin
            item.edge_a = make_edge(rw, x0, y0, x1, y1);
        end
        else
        begin
            item.edge_a = make_edge(rw, x1, y1, x2, y2);
        end
        item.edge_b = make_edge(rw, x0, y0, x2, y2);
        item.color  = fill_color;
    end

endmodule

>>> src/tss_edge_queue.sv
// short queue of classified items between the front and back parts
// depends on tss_pkg
module tss_edge_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  tss_pkg::tss_item_t wr_item,
    input  logic               rd_en,
    output tss_pkg::tss_item_t rd_item,
    output logic               rd_valid,
    output logic               is_full
);

    localparam int PB = tss_pkg::QPTR_BITS;

    tss_pkg::tss_item_t mem_reg [tss_pkg::QUEUE_DEPTH];
    logic [PB-1:0] wptr_reg, rptr_reg;
    logic [PB:0]   count_reg, count_next;

    assign rd_item  = mem_reg[rptr_reg];
    assign rd_valid = (count_reg != '0);
    assign is_full  = (count_reg == (PB+1)'(tss_pkg::QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg + (PB+1)'(wr_en) - (PB+1)'(rd_en);
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

>>> src/tss_back.sv
// back part: multiply, pipelined division, ordering, clipping, result queue
// depends on tss_pkg
module tss_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tss_pkg::tss_item_t            item,
    input  logic                          item_valid,
    output logic                          item_take,
    input  logic [tss_pkg::DIM_BITS-1:0]  frame_width,
    input  logic                          pop,
    output logic                          empty,
    output tss_pkg::tss_span_t            span
);

    localparam int QB  = tss_pkg::Q_BITS;
    localparam int XB  = tss_pkg::X_BITS;
    localparam int PRB = tss_pkg::PROD_BITS;

    logic en;
    logic m_valid_reg, n_valid_reg, f_valid_reg;
    logic [QB-1:0] d_valid_reg;
    tss_pkg::tss_mwork_t m_reg;
    tss_pkg::tss_dwork_t n_reg;
    tss_pkg::tss_dwork_t d_reg [QB];
    tss_pkg::tss_fwork_t f_reg;
    tss_pkg::tss_span_t  c_span;
    tss_pkg::tss_span_t  obuf_reg [2];
    logic       owptr_reg, orptr_reg;
    logic [1:0] ocount_reg;
    logic       o_wr, o_rd;

    // the whole pipe moves while the result queue has room
    assign en        = (ocount_reg != 2'd2);
    assign item_take = en && item_valid;
    assign o_wr      = en && f_valid_reg;
    assign o_rd      = pop && (ocount_reg != 2'd0);
    assign empty     = (ocount_reg == 2'd0);
    assign span      = obuf_reg[orptr_reg];

    function automatic tss_pkg::tss_prod_t mult(tss_pkg::tss_edge_t e);
        tss_pkg::tss_prod_t p;
        logic signed [tss_pkg::DX_BITS-1:0] ts;
        ts     = signed'({1'b0, e.t});
        p.prod = PRB'(ts) * PRB'(e.dx);
        p.sx   = e.sx;
        p.den  = e.den;
        p.flat = e.flat;
        return p;
    endfunction

    // order the two x values and clip to the frame
    always_comb
    begin
        logic signed [XB-1:0] a, b, w;
        logic [tss_pkg::DIM_BITS-1:0] wc;
        wc = (frame_width > tss_pkg::MAX_DIM_VAL) ? tss_pkg::MAX_DIM_VAL : frame_width;
        w  = signed'({{(XB-tss_pkg::DIM_BITS){1'b0}}, wc});
        a  = (f_reg.xa > f_reg.xb) ? f_reg.xb : f_reg.xa;
        b  = (f_reg.xa > f_reg.xb) ? f_reg.xa : f_reg.xb;
        c_span.color   = f_reg.color;
        c_span.covered = f_reg.row_ok && !((b < 0) || (a >= w));
        if (a < 0)
        begin
            a = '0;
        end
        if (b >= w)
        begin
            b = w - XB'(1);
        end
        c_span.start = c_span.covered ? a[tss_pkg::ROW_BITS-1:0] : '0;
        c_span.stop  = c_span.covered ? b[tss_pkg::ROW_BITS-1:0] : '0;
    end

    // stage valids and result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            n_valid_reg <= 1'b0;
            d_valid_reg <= '0;
            f_valid_reg <= 1'b0;
            owptr_reg   <= 1'b0;
            orptr_reg   <= 1'b0;
            ocount_reg  <= 2'd0;
        end
        else
        begin
            if (en)
            begin
                m_valid_reg <= item_valid;
                n_valid_reg <= m_valid_reg;
                d_valid_reg <= {d_valid_reg[QB-2:0], n_valid_reg};
                f_valid_reg <= d_valid_reg[QB-1];
            end
            if (o_wr)
            begin
                owptr_reg <= ~owptr_reg;
            end
            if (o_rd)
            begin
                orptr_reg <= ~orptr_reg;
            end
            ocount_reg <= ocount_reg + 2'(o_wr) - 2'(o_rd);
        end
    end

    // multiply, numerator and finish stages and result queue storage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg.row_ok <= item.row_ok;
            m_reg.pa     <= mult(item.edge_a);
            m_reg.pb     <= mult(item.edge_b);
            m_reg.color  <= item.color;
            n_reg.row_ok <= m_reg.row_ok;
            n_reg.da     <= tss_pkg::div_start(m_reg.pa);
            n_reg.db     <= tss_pkg::div_start(m_reg.pb);
            n_reg.color  <= m_reg.color;
            f_reg.row_ok <= d_reg[QB-1].row_ok;
            f_reg.xa     <= tss_pkg::div_finish(d_reg[QB-1].da);
            f_reg.xb     <= tss_pkg::div_finish(d_reg[QB-1].db);
            f_reg.color  <= d_reg[QB-1].color;
        end
        if (o_wr)
        begin
            obuf_reg[owptr_reg] <= c_span;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < QB; i++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (i == 0)
                begin
                    d_reg[i].row_ok <= n_reg.row_ok;
                    d_reg[i].da     <= tss_pkg::div_step(n_reg.da, QB-1-i);
                    d_reg[i].db     <= tss_pkg::div_step(n_reg.db, QB-1-i);
                    d_reg[i].color  <= n_reg.color;
                end
                else
                begin
                    d_reg[i].row_ok <= d_reg[i-1].row_ok;
                    d_reg[i].da     <= tss_pkg::div_step(d_reg[i-1].da, QB-1-i);
                    d_reg[i].db     <= tss_pkg::div_step(d_reg[i-1].db, QB-1-i);
                    d_reg[i].color  <= d_reg[i-1].color;
                end
            end
        end
    end

endmodule

>>> src/triangle_scanline_span.sv
// triangle scanline span: one span per cycle sustained while the result queue
// has room; an accepted item passes the registered multiply, numerator, 18 division
// stages set by the 18 quotient bits and finish stages, then the clip into the result queue
// a 4-beat input queue and a 2-beat result queue let each side stall alone
// rst_n asynchronous active low: empties both queues and the pipe,
// frame_width back to 640 and frame_height to 480
`include "triangle_scanline_span_defines.svh"
module triangle_scanline_span
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [tss_pkg::DIM_BITS-1:0]          cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_a_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_a_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_b_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_b_y,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_c_x,
    input  logic signed [tss_pkg::COORD_BITS-1:0] vertex_c_y,
    input  logic [tss_pkg::ROW_BITS-1:0]          row,
    input  logic [tss_pkg::COLOR_BITS-1:0]        fill_color,
    input  logic                                  pop,
    output logic                                  empty,
    output logic                                  row_covered,
    output logic [tss_pkg::ROW_BITS-1:0]          span_start,
    output logic [tss_pkg::ROW_BITS-1:0]          span_end,
    output logic [tss_pkg::COLOR_BITS-1:0]        span_color
);

    localparam int DB = tss_pkg::DIM_BITS;

    logic [tss_pkg::DIM_BITS-1:0] frame_width_reg, frame_height_reg;
    tss_pkg::tss_item_t front_item, q_item;
    tss_pkg::tss_span_t span;
    logic q_full, q_valid, q_take, wr_en;

    assign full  = q_full;
    assign wr_en = push && !q_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DB'(640);
            frame_height_reg <= DB'(480);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tss_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                tss_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tss_front u_front
    (
        .vertex_a_x   (vertex_a_x),
        .vertex_a_y   (vertex_a_y),
        .vertex_b_x   (vertex_b_x),
        .vertex_b_y   (vertex_b_y),
        .vertex_c_x   (vertex_c_x),
        .vertex_c_y   (vertex_c_y),
        .row          (row),
        .fill_color   (fill_color),
        .frame_height (frame_height_reg),
        .item         (front_item)
    );

    tss_edge_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_item  (front_item),
        .rd_en    (q_take),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .is_full  (q_full)
    );

    tss_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (q_item),
        .item_valid  (q_valid),
        .item_take   (q_take),
        .frame_width (frame_width_reg),
        .pop         (pop),
        .empty       (empty),
        .span        (span)
    );

    assign row_covered = span.covered;
    assign span_start  = span.start;
    assign span_end    = span.stop;
    assign span_color  = span.color;

    // uncovered beats carry zero ends, covered beats are ordered
    `TSS_ASSERT_IMPLIES(a_uncovered_zero, clk, rst_n, !empty && !row_covered, span_start == '0 && span_end == '0)
    `TSS_ASSERT_NEVER(a_span_order, clk, rst_n, !empty && row_covered && (span_start > span_end))

endmodule
